// ===== rtl/rbf_pkg.sv =====
`timescale 1ns / 1ps

package rbf_pkg;

    localparam int MODE_W = 3;
    localparam int BYTE_W = 8;
    localparam int CNT_W  = 13;

    // Largest capacity the 13-bit register can name, and the capacity after reset
    localparam int CAP_FIELD_MAX = 8191;
    localparam int CAP_RESET_VAL = 4096;

    localparam logic [MODE_W-1:0] MODE_WRITE = 3'd0;
    localparam logic [MODE_W-1:0] MODE_READ  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_PEEK  = 3'd2;
    localparam logic [MODE_W-1:0] MODE_SKIP  = 3'd3;
    localparam logic [MODE_W-1:0] MODE_CLEAR = 3'd4;

    typedef enum logic [2:0] {
        OP_WRITE,
        OP_READ,
        OP_PEEK,
        OP_SKIP,
        OP_CLEAR,
        OP_NOP
    } t_op;

    typedef struct packed {
        t_op               op;
        logic [BYTE_W-1:0] data;
        logic [CNT_W-1:0]  amount;
    } t_cmd;

    typedef enum logic {
        BS_EXEC,
        BS_WAIT
    } t_bstate;

endpackage

// ===== rtl/rbf_in_if.sv =====
`timescale 1ns / 1ps

interface rbf_in_if;
    logic                        valid;
    logic                        ready;
    logic [rbf_pkg::MODE_W-1:0]  mode;
    logic [rbf_pkg::BYTE_W-1:0]  data_in;
    logic [rbf_pkg::CNT_W-1:0]   amount;

    modport source (output valid, output mode, output data_in, output amount, input ready);
    modport sink   (input valid, input mode, input data_in, input amount, output ready);
endinterface

// ===== rtl/rbf_out_if.sv =====
`timescale 1ns / 1ps

interface rbf_out_if;
    logic                        valid;
    logic                        ready;
    logic [rbf_pkg::BYTE_W-1:0]  data_out;
    logic                        ok;
    logic [rbf_pkg::CNT_W-1:0]   amount_done;
    logic [rbf_pkg::CNT_W-1:0]   fill_level;
    logic [rbf_pkg::CNT_W-1:0]   space_left;

    modport source (output valid, output data_out, output ok, output amount_done,
                    output fill_level, output space_left, input ready);
    modport sink   (input valid, input data_out, input ok, input amount_done,
                    input fill_level, input space_left, output ready);
endinterface

// ===== rtl/rbf_cfg_if.sv =====
`timescale 1ns / 1ps

interface rbf_cfg_if;
    logic                       valid;
    logic                       ready;
    logic [rbf_pkg::CNT_W-1:0]  capacity_in_use;

    modport source (output valid, output capacity_in_use, input ready);
    modport sink   (input valid, input capacity_in_use, output ready);
endinterface

// ===== rtl/rbf_ram.sv =====
`timescale 1ns / 1ps

module rbf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/rbf_front.sv =====
`timescale 1ns / 1ps

module rbf_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    rbf_in_if.sink        i_in,
    output rbf_pkg::t_cmd o_cmd,
    output logic          o_cmd_valid,
    input  logic          i_cmd_ready
);
    import rbf_pkg::*;

    t_cmd r_cmd;
    logic r_valid;
    t_op  dec_op;
    logic accept;

    always_comb begin
        unique case (i_in.mode)
            MODE_WRITE: dec_op = OP_WRITE;
            MODE_READ:  dec_op = OP_READ;
            MODE_PEEK:  dec_op = OP_PEEK;
            MODE_SKIP:  dec_op = OP_SKIP;
            MODE_CLEAR: dec_op = OP_CLEAR;
            default:    dec_op = OP_NOP;
        endcase
    end

    assign i_in.ready = !r_valid || i_cmd_ready;
    assign accept     = i_in.valid && i_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (i_cmd_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd.op     <= dec_op;
            r_cmd.data   <= i_in.data_in;
            r_cmd.amount <= i_in.amount;
        end
    end

    assign o_cmd       = r_cmd;
    assign o_cmd_valid = r_valid;

endmodule

// ===== rtl/rbf_cmd_queue.sv =====
`timescale 1ns / 1ps

module rbf_cmd_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push_valid,
    input  rbf_pkg::t_cmd i_push_cmd,
    output logic          o_push_ready,
    output logic          o_pop_valid,
    output rbf_pkg::t_cmd o_pop_cmd,
    input  logic          i_pop_ready
);
    import rbf_pkg::*;

    t_cmd       r_slot [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       push;
    logic       pop;

    assign o_push_ready = (r_cnt != 2'd2);
    assign o_pop_valid  = (r_cnt != 2'd0);
    assign o_pop_cmd    = r_slot[r_rp];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = i_pop_ready && o_pop_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= !r_wp;
            end
            if (pop) begin
                r_rp <= !r_rp;
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (pop && !push) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_slot[r_wp] <= i_push_cmd;
        end
    end

endmodule

// ===== rtl/rbf_back.sv =====
`timescale 1ns / 1ps

module rbf_back #(
    parameter int STORE_DEPTH = 4096
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cmd_valid,
    input  rbf_pkg::t_cmd i_cmd,
    output logic          o_cmd_ready,
    rbf_cfg_if.sink       i_cfg,
    rbf_out_if.source     o_res
);
    import rbf_pkg::*;

    localparam int IW      = $clog2(STORE_DEPTH);
    localparam int SW      = ((IW > CNT_W) ? IW : CNT_W) + 1;
    localparam int CAP_MAX = (STORE_DEPTH < CAP_FIELD_MAX) ? STORE_DEPTH : CAP_FIELD_MAX;
    localparam int CAP_RST = (STORE_DEPTH < CAP_RESET_VAL) ? STORE_DEPTH : CAP_RESET_VAL;

    t_bstate           r_state;
    t_bstate           n_state;
    logic [IW-1:0]     r_rd;
    logic [IW-1:0]     r_wr;
    logic [CNT_W-1:0]  r_cnt;
    logic [CNT_W-1:0]  r_cap;
    logic              r_out_valid;
    logic [BYTE_W-1:0] r_data;
    logic              r_ok;
    logic [CNT_W-1:0]  r_done;
    logic [CNT_W-1:0]  r_fill;
    logic [CNT_W-1:0]  r_space;

    logic [IW-1:0]     n_rd;
    logic [IW-1:0]     n_wr;
    logic [CNT_W-1:0]  n_cnt;
    logic              take;
    logic              need_ram;
    logic              res_ok;
    logic [CNT_W-1:0]  res_done;
    logic [CNT_W-1:0]  skip_n;
    logic [CNT_W-1:0]  rd_step;
    logic [IW-1:0]     rd_sum;
    logic [IW-1:0]     wr_sum;
    logic              ram_we;
    logic [IW-1:0]     ram_raddr;
    logic [BYTE_W-1:0] ram_rdata;
    logic [CNT_W-1:0]  cap_wr;

    function automatic logic [IW-1:0] f_wrap(input logic [IW-1:0]    idx,
                                             input logic [CNT_W-1:0] step,
                                             input logic [CNT_W-1:0] cap);
        logic [SW-1:0] s;
        s = SW'(idx) + SW'(step);
        if (s >= SW'(cap)) begin
            s = s - SW'(cap);
        end
        return s[IW-1:0];
    endfunction

    // Clamp capacity writes into 1..min(STORE_DEPTH, field max)
    always_comb begin
        if (i_cfg.capacity_in_use == '0) begin
            cap_wr = CNT_W'(1);
        end else if (32'(i_cfg.capacity_in_use) > CAP_MAX) begin
            cap_wr = CNT_W'(CAP_MAX);
        end else begin
            cap_wr = i_cfg.capacity_in_use;
        end
    end

    assign i_cfg.ready = 1'b1;

    assign take        = (r_state == BS_EXEC) && i_cmd_valid && (!r_out_valid || o_res.ready);
    assign o_cmd_ready = take;

    assign skip_n  = (i_cmd.amount < r_cnt) ? i_cmd.amount : r_cnt;
    assign rd_step = (i_cmd.op == OP_PEEK) ? i_cmd.amount :
                     (i_cmd.op == OP_SKIP) ? skip_n : CNT_W'(1);
    assign rd_sum  = f_wrap(r_rd, rd_step, r_cap);
    assign wr_sum  = f_wrap(r_wr, CNT_W'(1), r_cap);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            BS_EXEC: begin
                if (take && need_ram) begin
                    n_state = BS_WAIT;
                end
            end
            BS_WAIT: n_state = BS_EXEC;
            default: n_state = BS_EXEC;
        endcase
    end

    always_comb begin
        n_rd      = r_rd;
        n_wr      = r_wr;
        n_cnt     = r_cnt;
        res_ok    = 1'b0;
        res_done  = '0;
        need_ram  = 1'b0;
        ram_we    = 1'b0;
        ram_raddr = r_rd;
        unique case (i_cmd.op)
            OP_WRITE: begin
                if (r_cnt < r_cap) begin
                    ram_we   = take;
                    n_wr     = wr_sum;
                    n_cnt    = r_cnt + CNT_W'(1);
                    res_ok   = 1'b1;
                    res_done = CNT_W'(1);
                end
            end
            OP_READ: begin
                if (r_cnt != '0) begin
                    need_ram = 1'b1;
                    n_rd     = rd_sum;
                    n_cnt    = r_cnt - CNT_W'(1);
                    res_ok   = 1'b1;
                    res_done = CNT_W'(1);
                end
            end
            OP_PEEK: begin
                if (i_cmd.amount < r_cnt) begin
                    need_ram  = 1'b1;
                    ram_raddr = rd_sum;
                    res_ok    = 1'b1;
                    res_done  = CNT_W'(1);
                end
            end
            OP_SKIP: begin
                n_rd     = rd_sum;
                n_cnt    = r_cnt - skip_n;
                res_ok   = (skip_n != '0);
                res_done = skip_n;
            end
            OP_CLEAR: begin
                n_rd   = '0;
                n_wr   = '0;
                n_cnt  = '0;
                res_ok = 1'b1;
            end
            OP_NOP: begin
            end
            default: begin
            end
        endcase
    end

    rbf_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (STORE_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_wr),
        .i_wdata (i_cmd.data),
        .i_re    (take && need_ram),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BS_EXEC;
            r_rd        <= '0;
            r_wr        <= '0;
            r_cnt       <= '0;
            r_cap       <= CNT_W'(CAP_RST);
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg.valid) begin
                r_cap <= cap_wr;
                r_rd  <= '0;
                r_wr  <= '0;
                r_cnt <= '0;
            end else if (take) begin
                r_rd  <= n_rd;
                r_wr  <= n_wr;
                r_cnt <= n_cnt;
            end
            // Hold the beat back through the wait state while the store read completes
            if (take) begin
                r_out_valid <= !need_ram;
            end else if (r_state == BS_WAIT) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_data  <= '0;
            r_ok    <= res_ok;
            r_done  <= res_done;
            r_fill  <= n_cnt;
            r_space <= r_cap - n_cnt;
        end else if (r_state == BS_WAIT) begin
            r_data <= ram_rdata;
        end
    end

    assign o_res.valid       = r_out_valid;
    assign o_res.data_out    = r_data;
    assign o_res.ok          = r_ok;
    assign o_res.amount_done = r_done;
    assign o_res.fill_level  = r_fill;
    assign o_res.space_left  = r_space;

endmodule

// ===== rtl/byte_ring_fifo_with_peek_skip.sv =====
`timescale 1ns / 1ps

// Channel   Dir  Payload                                            Handshake
// i_in      in   mode, data_in, amount                              valid/ready
// o_res     out  data_out, ok, amount_done, fill_level, space_left  valid/ready
// i_cfg     in   capacity_in_use                                    valid/ready (always ready)
//
// The back end completes write, skip, clear and undefined modes, and a failed read
// or peek, without a wait state; a successful read or peek passes through the wait
// state, set by the registered read port of the byte store.
// Synchronous active-low reset empties the ring and sets the capacity to
// min(4096, STORE_DEPTH); the store contents are not cleared.
// A two-entry command queue lets the front keep taking beats while the result
// register waits on o_res.ready.

module byte_ring_fifo_with_peek_skip #(
    parameter int STORE_DEPTH = 4096
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    rbf_in_if.sink    i_in,
    rbf_cfg_if.sink   i_cfg,
    rbf_out_if.source o_res
);
    import rbf_pkg::*;

    t_cmd front_cmd;
    logic front_valid;
    logic front_ready;
    t_cmd queue_cmd;
    logic queue_valid;
    logic queue_ready;

    rbf_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .o_cmd       (front_cmd),
        .o_cmd_valid (front_valid),
        .i_cmd_ready (front_ready)
    );

    rbf_cmd_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (front_valid),
        .i_push_cmd   (front_cmd),
        .o_push_ready (front_ready),
        .o_pop_valid  (queue_valid),
        .o_pop_cmd    (queue_cmd),
        .i_pop_ready  (queue_ready)
    );

    rbf_back #(
        .STORE_DEPTH (STORE_DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (queue_valid),
        .i_cmd       (queue_cmd),
        .o_cmd_ready (queue_ready),
        .i_cfg       (i_cfg),
        .o_res       (o_res)
    );

endmodule

// ===== sim/tb_byte_ring_fifo_with_peek_skip.sv =====
`timescale 1ns / 1ps

module tb_byte_ring_fifo_with_peek_skip;
    import rbf_pkg::*;

    localparam int STORE_DEPTH   = 4096;
    localparam int SETTLE_CYCLES = 8;
    localparam int REPORT_LINES  = 40;
    localparam int NUM_RUNS      = 6;

    localparam logic [MODE_W-1:0] MODE_UNDEF_LO = 3'd5;
    localparam logic [MODE_W-1:0] MODE_UNDEF_HI = 3'd7;

    // Random runs: capacity written first, then beats under the given idle rates
    localparam int RUN_CAP       [NUM_RUNS] = '{5, 4096, 0, 200, 8191, 2};
    localparam int RUN_ITEMS     [NUM_RUNS] = '{150, 130, 90, 190, 140, 150};
    localparam int RUN_TX_IDLE   [NUM_RUNS] = '{19, 19, 50, 50, 0, 0};
    localparam int RUN_RX_IDLE   [NUM_RUNS] = '{50, 50, 19, 19, 0, 0};
    localparam int RUN_WRITE_PCT [NUM_RUNS] = '{45, 50, 45, 60, 50, 45};

    typedef struct {
        logic [BYTE_W-1:0] data;
        logic              ok;
        logic [CNT_W-1:0]  done;
        logic [CNT_W-1:0]  fill;
        logic [CNT_W-1:0]  space;
    } t_ring_result;

    class byte_ring_checker;
        logic [BYTE_W-1:0] ring_bytes [STORE_DEPTH];
        int                cap;
        int                rd_pos;
        int                wr_pos;
        int                held;
        t_ring_result      pending_results [$];
        int                mismatch_count;

        function new();
            cap = (CAP_RESET_VAL < STORE_DEPTH) ? CAP_RESET_VAL : STORE_DEPTH;
            rd_pos = 0;
            wr_pos = 0;
            held = 0;
            mismatch_count = 0;
        endfunction

        function int wrap_step(int idx, int step);
            int s;
            s = idx + step;
            if (s >= cap) begin
                s -= cap;
            end
            return s;
        endfunction

        // Any capacity write also empties the ring
        function void set_capacity(logic [CNT_W-1:0] value);
            if (value == 0) begin
                cap = 1;
            end else if (int'(value) > STORE_DEPTH) begin
                cap = STORE_DEPTH;
            end else begin
                cap = int'(value);
            end
            rd_pos = 0;
            wr_pos = 0;
            held = 0;
        endfunction

        function void note_op(logic [MODE_W-1:0] mode, logic [BYTE_W-1:0] din,
                              logic [CNT_W-1:0] amt);
            t_ring_result r;
            int           n;
            r.data = '0;
            r.ok = 1'b0;
            r.done = '0;
            case (mode)
                MODE_WRITE: begin
                    if (held < cap) begin
                        ring_bytes[wr_pos] = din;
                        wr_pos = wrap_step(wr_pos, 1);
                        held++;
                        r.ok = 1'b1;
                        r.done = CNT_W'(1);
                    end
                end
                MODE_READ: begin
                    if (held > 0) begin
                        r.data = ring_bytes[rd_pos];
                        rd_pos = wrap_step(rd_pos, 1);
                        held--;
                        r.ok = 1'b1;
                        r.done = CNT_W'(1);
                    end
                end
                MODE_PEEK: begin
                    if (int'(amt) < held) begin
                        r.data = ring_bytes[wrap_step(rd_pos, int'(amt))];
                        r.ok = 1'b1;
                        r.done = CNT_W'(1);
                    end
                end
                MODE_SKIP: begin
                    n = (int'(amt) < held) ? int'(amt) : held;
                    rd_pos = wrap_step(rd_pos, n);
                    held -= n;
                    r.ok = (n > 0);
                    r.done = CNT_W'(n);
                end
                MODE_CLEAR: begin
                    rd_pos = 0;
                    wr_pos = 0;
                    held = 0;
                    r.ok = 1'b1;
                end
                default: begin
                end
            endcase
            r.fill = CNT_W'(held);
            r.space = CNT_W'(cap - held);
            pending_results.push_back(r);
        endfunction

        task report_mismatch(string msg);
            mismatch_count++;
            if (mismatch_count <= REPORT_LINES) begin
                $display("[%0t] MISMATCH: %s", $realtime, msg);
            end
        endtask

        task check_result(t_ring_result got);
            t_ring_result want;
            if (pending_results.size() == 0) begin
                report_mismatch($sformatf("result with nothing pending: data %0h ok %0d done %0d",
                                          got.data, got.ok, got.done));
            end else begin
                want = pending_results.pop_front();
                if (got.data !== want.data || got.ok !== want.ok || got.done !== want.done ||
                    got.fill !== want.fill || got.space !== want.space) begin
                    report_mismatch($sformatf(
                        "data %0h/%0h ok %0d/%0d done %0d/%0d fill %0d/%0d space %0d/%0d (got/exp)",
                        got.data, want.data, got.ok, want.ok, got.done, want.done,
                        got.fill, want.fill, got.space, want.space));
                end
            end
        endtask
    endclass

    logic i_clk;
    logic i_rst_n;

    rbf_in_if  in_ch ();
    rbf_cfg_if cfg_ch ();
    rbf_out_if res_ch ();

    byte_ring_checker sb = new();

    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    int rx_hold_req = 0;
    int items_in = 0;
    int results_out = 0;
    int cfg_writes = 0;

    byte_ring_fifo_with_peek_skip #(
        .STORE_DEPTH(STORE_DEPTH)
    ) i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .i_cfg   (cfg_ch),
        .o_res   (res_ch)
    );

    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    // Receiver: random stalls, plus long hold-offs on request
    initial begin
        int rx_hold_left;
        rx_hold_left = 0;
        res_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (rx_hold_req > 0) begin
                rx_hold_left = rx_hold_req;
                rx_hold_req = 0;
            end
            if (rx_hold_left > 0) begin
                rx_hold_left--;
                res_ch.ready <= 1'b0;
            end else begin
                res_ch.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        t_ring_result got;
        if (i_rst_n) begin
            if (cfg_ch.valid && cfg_ch.ready) begin
                sb.set_capacity(cfg_ch.capacity_in_use);
                cfg_writes++;
            end
            if (in_ch.valid && in_ch.ready) begin
                sb.note_op(in_ch.mode, in_ch.data_in, in_ch.amount);
                items_in++;
            end
            if (res_ch.valid && res_ch.ready) begin
                got.data = res_ch.data_out;
                got.ok = res_ch.ok;
                got.done = res_ch.amount_done;
                got.fill = res_ch.fill_level;
                got.space = res_ch.space_left;
                sb.check_result(got);
                results_out++;
            end
        end
    end

    task automatic send_op(logic [MODE_W-1:0] m, logic [BYTE_W-1:0] d, logic [CNT_W-1:0] a);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.mode <= m;
        in_ch.data_in <= d;
        in_ch.amount <= a;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
    endtask

    // Drop valid and hold until every pending result has come back
    task automatic wait_results();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic drain();
        wait_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_capacity(logic [CNT_W-1:0] value);
        drain();
        cfg_ch.valid <= 1'b1;
        cfg_ch.capacity_in_use <= value;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // Mostly offsets and counts near the fill level, sometimes the full field
    function automatic void pick_op(int held, int write_pct, output logic [MODE_W-1:0] m,
                                    output logic [BYTE_W-1:0] d, output logic [CNT_W-1:0] a);
        int roll;
        d = BYTE_W'($urandom_range(0, 255));
        a = CNT_W'($urandom_range(0, 8191));
        roll = $urandom_range(0, 99);
        if (roll < write_pct) begin
            m = MODE_WRITE;
        end else begin
            roll = $urandom_range(0, 99);
            if (roll < 40) begin
                m = MODE_READ;
            end else if (roll < 68) begin
                m = MODE_PEEK;
                if ($urandom_range(0, 9) < 8) begin
                    a = CNT_W'($urandom_range(0, held + 1));
                end
            end else if (roll < 88) begin
                m = MODE_SKIP;
                if ($urandom_range(0, 9) < 6) begin
                    a = CNT_W'($urandom_range(0, 4));
                end else if ($urandom_range(0, 9) < 7) begin
                    a = CNT_W'($urandom_range(0, held + 2));
                end
            end else if (roll < 94) begin
                m = MODE_CLEAR;
            end else begin
                m = MODE_W'($urandom_range(MODE_UNDEF_LO, MODE_UNDEF_HI));
            end
        end
    endfunction

    initial begin
        logic [MODE_W-1:0] m;
        logic [BYTE_W-1:0] d;
        logic [CNT_W-1:0]  a;

        i_rst_n <= 1'b0;
        in_ch.valid <= 1'b0;
        in_ch.mode <= MODE_WRITE;
        in_ch.data_in <= '0;
        in_ch.amount <= '0;
        cfg_ch.valid <= 1'b0;
        cfg_ch.capacity_in_use <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty-ring failures, peek bounds, oversize skip, undefined modes
        send_op(MODE_READ, 8'h00, 13'd0);
        send_op(MODE_PEEK, 8'hFF, 13'd0);
        send_op(MODE_SKIP, 8'h00, 13'd4);
        send_op(MODE_WRITE, 8'h00, 13'h1FFF);
        send_op(MODE_WRITE, 8'hFF, 13'd0);
        send_op(MODE_WRITE, 8'h5A, 13'd0);
        send_op(MODE_PEEK, 8'h00, 13'd1);
        send_op(MODE_PEEK, 8'h00, 13'd3);
        send_op(MODE_PEEK, 8'h00, 13'h1FFF);
        send_op(MODE_READ, 8'h00, 13'd0);
        send_op(MODE_SKIP, 8'h00, 13'h1FFF);
        for (int k = MODE_UNDEF_LO; k <= MODE_UNDEF_HI; k++) begin
            send_op(MODE_W'(k), 8'hC3, 13'h0AAA);
        end
        send_op(MODE_WRITE, 8'h3C, 13'd0);
        send_op(MODE_SKIP, 8'h00, 13'd0);
        send_op(MODE_CLEAR, 8'h00, 13'd0);
        send_op(MODE_READ, 8'h00, 13'd0);

        // Tiny ring: fill, drop on full, wrap both indices
        write_capacity(13'd3);
        send_op(MODE_WRITE, 8'hA5, 13'd0);
        send_op(MODE_WRITE, 8'h96, 13'd0);
        send_op(MODE_WRITE, 8'h69, 13'd0);
        send_op(MODE_WRITE, 8'h0F, 13'd0);
        send_op(MODE_READ, 8'h00, 13'd0);
        send_op(MODE_WRITE, 8'h77, 13'd0);
        send_op(MODE_PEEK, 8'h00, 13'd2);

        for (int r = 0; r < NUM_RUNS; r++) begin
            write_capacity(CNT_W'(RUN_CAP[r]));
            tx_idle_pct = RUN_TX_IDLE[r];
            rx_idle_pct = RUN_RX_IDLE[r];
            for (int i = 0; i < RUN_ITEMS[r]; i++) begin
                if (r == 4 && i == 30) begin
                    rx_hold_req = 80;
                end
                if (r == 4 && i == 100) begin
                    wait_results();
                end
                pick_op(sb.held, RUN_WRITE_PCT[r], m, d, a);
                send_op(m, d, a);
            end
        end

        drain();
        $display("Ran %0d operations, checked %0d results across %0d capacity settings,",
                 items_in, results_out, cfg_writes + 1);
        $display("with wrap, full and empty edges, output back-pressure and undefined modes.");
        if (sb.mismatch_count == 0 && sb.pending_results.size() == 0) begin
            $display("byte_ring_fifo_with_peek_skip regression: pass");
        end else begin
            $display("byte_ring_fifo_with_peek_skip regression: fail");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("Timed out with %0d results still pending", sb.pending_results.size());
        $display("byte_ring_fifo_with_peek_skip regression: fail");
        $finish;
    end

endmodule
